### rtl/direction_snap_to_vanishing_points_macros.svh
// assertion helpers for the direction snap block
`ifndef DIRECTION_SNAP_TO_VANISHING_POINTS_MACROS_SVH
`define DIRECTION_SNAP_TO_VANISHING_POINTS_MACROS_SVH

// explicit clock and reset
`define DSVP_CHECK_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// block clock and reset
`define DSVP_CHECK(lbl, prop, msg) `DSVP_CHECK_CLK(lbl, clk, rst, prop, msg)

`endif

### rtl/dsvp_pkg.sv
// ----------------------------------------------------------------------------
// dsvp_pkg
// types, widths and command codes shared by the direction snap modules
// ----------------------------------------------------------------------------
`default_nettype none

package dsvp_pkg;

  localparam int COORD_W    = 16;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 16;
  localparam int NUM_AXES   = 4;
  localparam int AXIS_STEP  = 10;
  localparam int DIR_W      = 5;
  localparam int CNT_W      = 5;
  localparam int IDX_W      = 4;
  localparam int STEP_W     = 4;

  localparam int VEC_W    = COORD_W + 1;
  localparam int SQ_W     = 2 * VEC_W;
  localparam int DOT_W    = SQ_W + 1;
  localparam int D2_W     = 2 * SQ_W;
  localparam int CMP_W    = D2_W + SQ_W;
  localparam int ROOT_MSB = COORD_W + FRAC_BITS;
  localparam int ROOT_W   = ROOT_MSB + 1;
  localparam int BIT_W    = $clog2(ROOT_W);
  localparam int TGT_W    = SQ_W + 2 * FRAC_BITS;
  localparam int TRIAL_W  = 2 * ROOT_W + SQ_W;
  localparam int RL_W     = ROOT_W + SQ_W;
  localparam int SUM_W    = D2_W - FRAC_BITS + 2;
  localparam int DIR_LAST = NUM_AXES + MAX_POINTS - 1;

  localparam int IN_DATA_W  = ((2 * COORD_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_W + DIR_W + 7) / 8) * 8;

  // axis candidates
  localparam logic [DIR_W-1:0] K_POS_X = DIR_W'(0);
  localparam logic [DIR_W-1:0] K_NEG_X = DIR_W'(1);
  localparam logic [DIR_W-1:0] K_POS_Y = DIR_W'(2);
  localparam logic [DIR_W-1:0] K_NEG_Y = DIR_W'(3);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_MOVE    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    C_IDLE, C_ACCEPT,
    C_LU_A, C_LU_B, C_LU_C,
    C_V, C_M1, C_M2, C_M3, C_M4, C_M5,
    C_P1, C_P2, C_P3, C_P4, C_P5, C_P6, C_TAKE,
    C_SQ_INIT, C_SQ_A, C_SQ_B,
    C_E1, C_E2, C_E3,
    C_OUT, C_ZOUT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [DIR_W-1:0] k;
    logic [BIT_W-1:0] b;
  } dp_cmd_t;

  typedef struct packed {
    logic lu_zero;
    logic lv_zero;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/dsvp_datapath.sv
// ----------------------------------------------------------------------------
// dsvp_datapath
// table, anchor, shared multipliers, compare and bit-serial root for the snap
// ----------------------------------------------------------------------------
`default_nettype none

module dsvp_datapath
  import dsvp_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  dp_cmd_t                    cmd,
  input  op_t                        in_op,
  input  wire logic signed [COORD_W-1:0] in_x,
  input  wire logic signed [COORD_W-1:0] in_y,
  input  wire logic [IDX_W-1:0]      in_idx,
  output dp_status_t                 status,
  output logic signed [COORD_W-1:0]  end_x,
  output logic signed [COORD_W-1:0]  end_y,
  output logic [DIR_W-1:0]           dir_idx,
  output logic                       rev,
  output logic                       no_dir
);

  localparam logic signed [VEC_W-1:0] AX_POS = VEC_W'(AXIS_STEP);
  localparam logic signed [VEC_W-1:0] AX_NEG = VEC_W'(-AXIS_STEP);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (COORD_W - 1)));

  logic signed [COORD_W-1:0] tab_x [MAX_POINTS];
  logic signed [COORD_W-1:0] tab_y [MAX_POINTS];
  logic signed [COORD_W-1:0] tab_qx, tab_qy;
  logic [IDX_W-1:0]          rd_addr;

  logic signed [COORD_W-1:0] anchor_x, anchor_y;
  logic signed [VEC_W-1:0]   ux, uy, vx, vy, bvx, bvy;
  logic signed [VEC_W-1:0]   ma, mb;
  logic signed [SQ_W-1:0]    sp, acc;
  logic [SQ_W-1:0]           lu, lv, best_l, dm;
  logic signed [DOT_W-1:0]   d;
  logic [SQ_W-1:0]           ba, bb;
  logic [D2_W-1:0]           bp, dm2, bd2, lhs_lo, rhs_lo;
  logic [CMP_W-1:0]          lhs, rhs;
  logic [ROOT_W-1:0]         r;
  logic [TGT_W-1:0]          r2l;
  logic [RL_W-1:0]           rl;
  logic [TRIAL_W-1:0]        trial, target;
  logic [BIT_W:0]            sh1, sh2;
  logic [DIR_W-1:0]          best_k;
  logic                      best_rev;
  logic signed [COORD_W-1:0] ex_r, ey_r;

  // anchor plus rounded signed offset, clamped to the coordinate range
  function automatic logic signed [COORD_W-1:0] snap(
    input logic signed [COORD_W-1:0] a,
    input logic [D2_W-1:0]           m,
    input logic                      neg
  );
    logic [D2_W-FRAC_BITS-1:0] q;
    logic [FRAC_BITS-1:0]      rem;
    logic                      up;
    logic signed [SUM_W-1:0]   off;
    logic signed [SUM_W-1:0]   s;
    q   = m[D2_W-1:FRAC_BITS];
    rem = m[FRAC_BITS-1:0];
    // round half to even on the magnitude
    up  = rem[FRAC_BITS-1] && ((rem[FRAC_BITS-2:0] != '0) || q[0]);
    off = SUM_W'(q) + SUM_W'(up);
    if (neg) off = -off;
    s = off + {{(SUM_W-COORD_W){a[COORD_W-1]}}, a};
    if (s > SAT_HI) s = SAT_HI;
    else if (s < SAT_LO) s = SAT_LO;
    return s[COORD_W-1:0];
  endfunction

  assign rd_addr = IDX_W'(cmd.k - DIR_W'(NUM_AXES));
  assign dm      = d[DOT_W-1] ? SQ_W'(-d) : SQ_W'(d);
  assign sh1     = {1'b0, cmd.b} + (BIT_W+1)'(1);
  assign sh2     = {cmd.b, 1'b0};
  assign target  = TRIAL_W'({lu, {(2*FRAC_BITS){1'b0}}});

  assign status.lu_zero = (lu == '0);
  assign status.lv_zero = (lv == '0);

  always_comb begin
    case (cmd.op)
      C_LU_A: begin ma = ux; mb = ux; end
      C_LU_B: begin ma = uy; mb = uy; end
      C_M1:   begin ma = vx; mb = vx; end
      C_M2:   begin ma = vy; mb = vy; end
      C_M3:   begin ma = ux; mb = vx; end
      C_M4:   begin ma = uy; mb = vy; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    case (cmd.op)
      C_P1: begin ba = dm;                 bb = dm;     end
      C_P2: begin ba = bp[SQ_W-1:0];       bb = best_l; end
      C_P3: begin ba = dm2[D2_W-1:SQ_W];   bb = best_l; end
      C_P4: begin ba = bd2[SQ_W-1:0];      bb = lv;     end
      C_P5: begin ba = bd2[D2_W-1:SQ_W];   bb = lv;     end
      C_E1: begin
        ba = SQ_W'(bvx[VEC_W-1] ? -bvx : bvx);
        bb = SQ_W'(r);
      end
      C_E2: begin
        ba = SQ_W'(bvy[VEC_W-1] ? -bvy : bvy);
        bb = SQ_W'(r);
      end
      default: begin ba = '0; bb = '0; end
    endcase
  end

  // table, registered read
  always_ff @(posedge clk) begin
    if (cmd.op == C_ACCEPT && in_op == OP_LOAD) begin
      tab_x[in_idx] <= in_x;
      tab_y[in_idx] <= in_y;
    end
    tab_qx <= tab_x[rd_addr];
    tab_qy <= tab_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x <= '0;
      anchor_y <= '0;
    end else if (cmd.op == C_ACCEPT && in_op == OP_PRESS) begin
      anchor_x <= in_x;
      anchor_y <= in_y;
    end
  end

  always_ff @(posedge clk) begin
    sp <= ma * mb;
    bp <= ba * bb;
    case (cmd.op)
      C_ACCEPT: begin
        if (in_op == OP_MOVE) begin
          ux <= {in_x[COORD_W-1], in_x} - {anchor_x[COORD_W-1], anchor_x};
          uy <= {in_y[COORD_W-1], in_y} - {anchor_y[COORD_W-1], anchor_y};
        end
      end
      C_LU_B: acc <= sp;
      C_LU_C: lu <= SQ_W'(acc + sp);
      C_V: begin
        case (cmd.k)
          K_POS_X: begin vx <= AX_POS; vy <= '0;     end
          K_NEG_X: begin vx <= AX_NEG; vy <= '0;     end
          K_POS_Y: begin vx <= '0;     vy <= AX_POS; end
          K_NEG_Y: begin vx <= '0;     vy <= AX_NEG; end
          default: begin
            vx <= {tab_qx[COORD_W-1], tab_qx} - {anchor_x[COORD_W-1], anchor_x};
            vy <= {tab_qy[COORD_W-1], tab_qy} - {anchor_y[COORD_W-1], anchor_y};
          end
        endcase
      end
      C_M2: acc <= sp;
      C_M3: lv <= SQ_W'(acc + sp);
      C_M4: acc <= sp;
      C_M5: d <= {acc[SQ_W-1], acc} + {sp[SQ_W-1], sp};
      C_P2: dm2 <= bp;
      C_P3: lhs_lo <= bp;
      C_P4: lhs <= {bp, {SQ_W{1'b0}}} + CMP_W'(lhs_lo);
      C_P5: rhs_lo <= bp;
      C_P6: rhs <= {bp, {SQ_W{1'b0}}} + CMP_W'(rhs_lo);
      C_TAKE: begin
        // first candidate always wins, later ones only on a strictly better angle
        if (cmd.k == K_POS_X || lhs > rhs) begin
          best_l   <= lv;
          bd2      <= dm2;
          bvx      <= vx;
          bvy      <= vy;
          best_rev <= d[DOT_W-1];
          best_k   <= cmd.k;
        end
      end
      C_SQ_INIT: begin
        r   <= '0;
        r2l <= '0;
        rl  <= '0;
      end
      // (r + 2^b)^2 * L from the running r^2*L and r*L
      C_SQ_A: trial <= TRIAL_W'(r2l) + (TRIAL_W'(rl) << sh1) + (TRIAL_W'(best_l) << sh2);
      C_SQ_B: begin
        if (trial <= target) begin
          r   <= r | (ROOT_W'(1) << cmd.b);
          r2l <= trial[TGT_W-1:0];
          rl  <= rl + (RL_W'(best_l) << cmd.b);
        end
      end
      C_E2: ex_r <= snap(anchor_x, bp, bvx[VEC_W-1] ^ best_rev);
      C_E3: ey_r <= snap(anchor_y, bp, bvy[VEC_W-1] ^ best_rev);
      C_OUT: begin
        end_x   <= ex_r;
        end_y   <= ey_r;
        dir_idx <= best_k;
        rev     <= best_rev;
        no_dir  <= 1'b0;
      end
      C_ZOUT: begin
        end_x   <= anchor_x;
        end_y   <= anchor_y;
        dir_idx <= K_POS_X;
        rev     <= 1'b0;
        no_dir  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/dsvp_ctrl.sv
// ----------------------------------------------------------------------------
// dsvp_ctrl
// sequencer: handshakes, candidate scan, root bits and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module dsvp_ctrl
  import dsvp_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  op_t              in_op,
  input  wire              cfg_we,
  input  wire [CNT_W-1:0]  cfg_wdata,
  output logic             out_valid,
  input  wire              out_ready,
  output dp_cmd_t          cmd,
  input  dp_status_t       status
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LU   = 7'b0000010,
    S_CAND = 7'b0000100,
    S_SQRT = 7'b0001000,
    S_ENDP = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_ZOUT = 7'b1000000
  } state_t;

  localparam logic [STEP_W-1:0] ST_0  = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_1  = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_2  = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_3  = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_4  = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_5  = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_6  = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_7  = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_8  = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_9  = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_10 = STEP_W'(10);
  localparam logic [STEP_W-1:0] ST_11 = STEP_W'(11);
  localparam logic [STEP_W-1:0] ST_12 = STEP_W'(12);
  localparam logic [STEP_W-1:0] ST_13 = STEP_W'(13);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [DIR_W-1:0]  k, k_next, last_k;
  logic [BIT_W-1:0]  b, b_next;
  logic [CNT_W-1:0]  point_count, count_lim;
  logic              pressed;
  cmd_op_t           cmd_op;
  logic              advance;

  assign count_lim = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
  assign last_k    = DIR_W'(NUM_AXES - 1) + DIR_W'(count_lim);
  assign in_ready  = (state == S_IDLE);
  assign cmd       = '{op: cmd_op, k: k, b: b};

  always_comb begin
    state_next = state;
    step_next  = step;
    k_next     = k;
    b_next     = b;
    cmd_op     = C_IDLE;
    advance    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_op = C_ACCEPT;
          if (in_op == OP_MOVE && pressed) begin
            state_next = S_LU;
            step_next  = ST_0;
          end
        end
      end
      S_LU: begin
        step_next = step + ST_1;
        case (step)
          ST_0: cmd_op = C_LU_A;
          ST_1: cmd_op = C_LU_B;
          ST_2: cmd_op = C_LU_C;
          default: begin
            step_next = ST_0;
            k_next    = K_POS_X;
            state_next = status.lu_zero ? S_ZOUT : S_CAND;
          end
        endcase
      end
      S_CAND: begin
        // a wait step lets the table read follow the new index
        step_next = step + ST_1;
        case (step)
          ST_0:  cmd_op = C_IDLE;
          ST_1:  cmd_op = C_V;
          ST_2:  cmd_op = C_M1;
          ST_3:  cmd_op = C_M2;
          ST_4:  cmd_op = C_M3;
          ST_5:  cmd_op = C_M4;
          ST_6:  cmd_op = C_M5;
          ST_7: begin
            if (status.lv_zero) advance = 1'b1;
            else cmd_op = C_P1;
          end
          ST_8:  cmd_op = C_P2;
          ST_9:  cmd_op = C_P3;
          ST_10: cmd_op = C_P4;
          ST_11: cmd_op = C_P5;
          ST_12: cmd_op = C_P6;
          ST_13: begin
            cmd_op  = C_TAKE;
            advance = 1'b1;
          end
          default: step_next = ST_0;
        endcase
        if (advance) begin
          step_next = ST_0;
          if (k == last_k) begin
            state_next = S_SQRT;
            b_next     = BIT_W'(ROOT_MSB);
          end else begin
            k_next = k + DIR_W'(1);
          end
        end
      end
      S_SQRT: begin
        case (step)
          ST_0: begin
            cmd_op    = C_SQ_INIT;
            step_next = ST_1;
          end
          ST_1: begin
            cmd_op    = C_SQ_A;
            step_next = ST_2;
          end
          default: begin
            cmd_op    = C_SQ_B;
            step_next = ST_1;
            if (b == '0) begin
              state_next = S_ENDP;
              step_next  = ST_0;
            end else begin
              b_next = b - BIT_W'(1);
            end
          end
        endcase
      end
      S_ENDP: begin
        step_next = step + ST_1;
        case (step)
          ST_0: cmd_op = C_E1;
          ST_1: cmd_op = C_E2;
          default: begin
            cmd_op     = C_E3;
            state_next = S_OUT;
            step_next  = ST_0;
          end
        endcase
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd_op     = C_OUT;
          state_next = S_IDLE;
        end
      end
      S_ZOUT: begin
        if (!out_valid || out_ready) begin
          cmd_op     = C_ZOUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= ST_0;
      k           <= '0;
      b           <= '0;
      pressed     <= 1'b0;
      point_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      k     <= k_next;
      b     <= b_next;
      if (cfg_we) point_count <= cfg_wdata;
      if (cmd_op == C_ACCEPT) begin
        if (in_op == OP_PRESS) pressed <= 1'b1;
        else if (in_op == OP_RELEASE) pressed <= 1'b0;
      end
      if (cmd_op == C_OUT || cmd_op == C_ZOUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/direction_snap_to_vanishing_points.sv
// a move runs the length step, a scan of every candidate (a zero one skips the
//   compare), the root and the endpoint steps; a zero vector skips to its result
// load, press, release and idle moves are taken on acceptance without a result
// throughput is one item at a time, set by the multiplier sequence per candidate
//   and the root that resolves one bit per trial and compare step pair
// synchronous active-high reset clears anchor, pressed flag, point count, out valid
// ----------------------------------------------------------------------------
// direction_snap_to_vanishing_points
// snaps a pointer drag to the nearest axis or vanishing point direction
// ----------------------------------------------------------------------------
`default_nettype none
`include "direction_snap_to_vanishing_points_macros.svh"

module direction_snap_to_vanishing_points
  import dsvp_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire [IN_DATA_W-1:0]   s_axis_tdata,  // pos_x, pos_y, point_index, zero pad
  input  wire [1:0]             s_axis_tuser,  // op
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // end_x, end_y, direction_index, zero pad
  output logic [1:0]            m_axis_tuser,  // reversed, no_direction
  input  wire                   cfg_we,
  input  wire [CNT_W-1:0]       cfg_wdata
);

  dp_cmd_t                   cmd;
  dp_status_t                status;
  op_t                       in_op;
  logic signed [COORD_W-1:0] end_x, end_y;
  logic [DIR_W-1:0]          dir_idx;
  logic                      rev, no_dir;

  assign in_op = op_t'(s_axis_tuser);

  dsvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (in_op),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  dsvp_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_op   (in_op),
    .in_x    (s_axis_tdata[COORD_W-1:0]),
    .in_y    (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .in_idx  (s_axis_tdata[2*COORD_W+IDX_W-1:2*COORD_W]),
    .status  (status),
    .end_x   (end_x),
    .end_y   (end_y),
    .dir_idx (dir_idx),
    .rev     (rev),
    .no_dir  (no_dir)
  );

  assign m_axis_tdata = OUT_DATA_W'({dir_idx, end_y, end_x});
  assign m_axis_tuser = {no_dir, rev};

  `DSVP_CHECK(a_nodir_clean, m_axis_tvalid && no_dir |-> dir_idx == K_POS_X && !rev, "zero vector result carries a direction")
  `DSVP_CHECK(a_dir_range, m_axis_tvalid |-> dir_idx <= DIR_W'(DIR_LAST), "direction index beyond candidates")
  `DSVP_CHECK(a_result_after_work, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result appeared without a move in flight")

endmodule

`default_nettype wire
